/* rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// types, constants and the sequencer states shared by the modular
// exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int MOD_BITS = 31;
  localparam int EXP_BITS = 32;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int CNT_W    = $clog2(MOD_BITS + 1);

  typedef logic [MOD_BITS-1:0] mod_word_t;
  typedef logic [EXP_BITS-1:0] exp_word_t;

  // register index taken from the upper address bit
  typedef enum logic {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    mod_word_t base_value;
    logic      last_in;
  } in_item_t;

  typedef struct packed {
    mod_word_t result_value;
    logic      last_out;
  } out_item_t;

  // request to the shared modular multiplier: go loads b, a is held stable
  typedef struct packed {
    logic      go;
    mod_word_t a;
    mod_word_t b;
  } mm_req_t;

  typedef struct packed {
    logic      done;
    mod_word_t value;
  } mm_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEXT,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

endpackage

/* rtl/mexp_modmul.sv */
// ----------------------------------------------------------------------------
// mexp_modmul
// bit-serial modular multiplier: one bit of b per cycle, msb first,
// r = 2r + b_i*a reduced by the modulus each step
// ----------------------------------------------------------------------------
module mexp_modmul (
  input  logic                clk,
  input  logic                rst,
  input  mexp_pkg::mod_word_t modulus,
  input  mexp_pkg::mm_req_t   req,
  output mexp_pkg::mm_rsp_t   rsp
);

  mexp_pkg::mod_word_t             r;
  mexp_pkg::mod_word_t             b_sh;
  logic [mexp_pkg::CNT_W-1:0]      count;
  logic                            done;

  logic [mexp_pkg::MOD_BITS:0]     m_ext;
  logic [mexp_pkg::MOD_BITS:0]     dbl;
  logic [mexp_pkg::MOD_BITS:0]     dbl_sub;
  logic [mexp_pkg::MOD_BITS:0]     sum;
  logic [mexp_pkg::MOD_BITS:0]     sum_sub;
  mexp_pkg::mod_word_t             half;
  mexp_pkg::mod_word_t             added;
  mexp_pkg::mod_word_t             r_next;

  always_comb begin
    m_ext   = {1'b0, modulus};
    dbl     = {r, 1'b0};
    dbl_sub = dbl - m_ext;
    half    = (dbl >= m_ext) ? dbl_sub[mexp_pkg::MOD_BITS-1:0]
                             : dbl[mexp_pkg::MOD_BITS-1:0];
    sum     = {1'b0, half} + {1'b0, req.a};
    sum_sub = sum - m_ext;
    added   = (sum >= m_ext) ? sum_sub[mexp_pkg::MOD_BITS-1:0]
                             : sum[mexp_pkg::MOD_BITS-1:0];
    r_next  = b_sh[mexp_pkg::MOD_BITS-1] ? added : half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (req.go) begin
      count <= mexp_pkg::CNT_W'(mexp_pkg::MOD_BITS);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == mexp_pkg::CNT_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      r    <= '0;
      b_sh <= req.b;
    end else if (count != '0) begin
      r    <= r_next;
      b_sh <= {b_sh[mexp_pkg::MOD_BITS-2:0], 1'b0};
    end
  end

  assign rsp.done  = done;
  assign rsp.value = r;

endmodule

/* rtl/modular_exponentiation_top.sv */
// sequence: reduce the base, then per exponent bit up to its top set bit a sequencing step
// and the squaring, with a multiply between them when the bit is set, then a last
// sequencing step and the done state to finish; modulus below two: straight to done
// base reducing to zero: reduction then done; exponent zero: reduction, sequencing, done
// one item at a time: the next is accepted in the cycle after the result transfer
// result strobe done lasts one cycle; reset (rst, synchronous): idle, modulus 2, exponent 1
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// right-to-left square-and-multiply over a shared serial modular multiplier,
// with modulus and exponent in an apb register file
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0]      paddr,
  input  logic [mexp_pkg::DATA_W-1:0]      pwdata,
  output logic [mexp_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             start,
  input  mexp_pkg::in_item_t               operand,
  output logic                             busy,
  output logic                             done,
  output mexp_pkg::out_item_t              result
);

  mexp_pkg::state_t     state;
  mexp_pkg::state_t     state_next;
  mexp_pkg::mod_word_t  modulus;
  mexp_pkg::exp_word_t  exponent;
  mexp_pkg::mod_word_t  acc;
  mexp_pkg::mod_word_t  rb;
  mexp_pkg::exp_word_t  exp_sh;
  logic                 last;
  logic                 mod_small;
  logic                 wr_en;
  mexp_pkg::reg_idx_t   reg_idx;
  mexp_pkg::mm_req_t    mm_req;
  mexp_pkg::mm_rsp_t    mm_rsp;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = mexp_pkg::reg_idx_t'(paddr[mexp_pkg::ADDR_W-1]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign prdata  = (reg_idx == mexp_pkg::REG_EXPONENT) ? exponent
                                                       : mexp_pkg::DATA_W'(modulus);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= mexp_pkg::mod_word_t'(2);
      exponent <= mexp_pkg::exp_word_t'(1);
    end else if (wr_en) begin
      case (reg_idx)
        mexp_pkg::REG_MODULUS:  modulus  <= pwdata[mexp_pkg::MOD_BITS-1:0];
        mexp_pkg::REG_EXPONENT: exponent <= pwdata[mexp_pkg::EXP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // modulus of zero or one gives zero for every base
  assign mod_small = (modulus[mexp_pkg::MOD_BITS-1:1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = mod_small ? mexp_pkg::ST_DONE : mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mm_rsp.done) begin
          state_next = (mm_rsp.value == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_NEXT;
        end
      end
      mexp_pkg::ST_NEXT: begin
        if (exp_sh == '0) begin
          state_next = mexp_pkg::ST_DONE;
        end else if (exp_sh[0]) begin
          state_next = mexp_pkg::ST_MUL;
        end else begin
          state_next = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_MUL: begin
        if (mm_rsp.done) begin
          state_next = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_SQR: begin
        if (mm_rsp.done) begin
          state_next = mexp_pkg::ST_NEXT;
        end
      end
      mexp_pkg::ST_DONE: begin
        state_next = mexp_pkg::ST_IDLE;
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy   = (state != mexp_pkg::ST_IDLE);
    done   = (state == mexp_pkg::ST_DONE);
    result = '{result_value: acc, last_out: last};
    // base reduction is 1 * base mod m, so a defaults to one
    mm_req.a = mexp_pkg::mod_word_t'(1);
    mm_req.b = rb;
    mm_req.go = 1'b0;
    case (state)
      mexp_pkg::ST_IDLE: begin
        mm_req.b  = operand.base_value;
        mm_req.go = start & ~mod_small;
      end
      mexp_pkg::ST_NEXT: begin
        mm_req.go = (exp_sh != '0);
      end
      mexp_pkg::ST_MUL: begin
        mm_req.a  = acc;
        // squaring starts as soon as the multiply finishes
        mm_req.go = mm_rsp.done;
      end
      mexp_pkg::ST_SQR: begin
        mm_req.a  = rb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      mexp_pkg::ST_IDLE: begin
        if (start) begin
          last   <= operand.last_in;
          exp_sh <= exponent;
          acc    <= '0;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mm_rsp.done) begin
          rb  <= mm_rsp.value;
          acc <= (mm_rsp.value == '0) ? mexp_pkg::mod_word_t'(0)
                                      : mexp_pkg::mod_word_t'(1);
        end
      end
      mexp_pkg::ST_MUL: begin
        if (mm_rsp.done) begin
          acc <= mm_rsp.value;
        end
      end
      mexp_pkg::ST_SQR: begin
        if (mm_rsp.done) begin
          rb     <= mm_rsp.value;
          exp_sh <= {1'b0, exp_sh[mexp_pkg::EXP_BITS-1:1]};
        end
      end
      default: ;
    endcase
  end

  mexp_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (mm_req),
    .rsp     (mm_rsp)
  );

endmodule

/* rtl/mexp_checker.sv */
// ----------------------------------------------------------------------------
// mexp_checker
// port-level checks on the item handshake of the exponentiation block
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // a result only appears while an item is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // one strobe per item, then ready again
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result transfer");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
